// File: sv/gvsf_pkg.sv
// ----------------------------------------------------------------------------
// gvsf_pkg
// Shared widths, register indexes and the divider control word for the
// Gouraud vertex setup block.
// ----------------------------------------------------------------------------
package gvsf_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned QUO_W   = WORD_W + 1;
    localparam int unsigned COL_W   = 8;
    localparam int unsigned NUM_W   = WORD_W + COL_W;
    localparam int unsigned DEPTH_W = WORD_W + 1;
    localparam int unsigned CNT_W   = 6;

    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned M_DATA_W = 176;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_END    = 2'd2;

    localparam logic [WORD_W-1:0]  FOG_END_RESET = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]  RECIP_SAT     = 32'hFFFF_FFFF;
    localparam logic [QUO_W-1:0]   RECIP_NUMER   = 33'h1_0000_0000;
    localparam logic [DEPTH_W-1:0] ONE_Q16       = 33'h0_0001_0000;
    localparam logic [COL_W-1:0]   FOG_FULL      = 8'hFF;
    localparam logic [COL_W-1:0]   FOG_NONE      = 8'h00;

    localparam logic [CNT_W-1:0] RECIP_STEPS_M1 = 6'd32;
    localparam logic [CNT_W-1:0] FOG_STEPS_M1   = 6'd7;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [WORD_W-1:0] rem_init;
        logic [QUO_W-1:0]  dq_init;
        logic [WORD_W-1:0] divisor;
    } div_ctrl_t;

endpackage

// File: sv/gvsf_div.sv
// ----------------------------------------------------------------------------
// gvsf_div
// Radix-2 restoring divider, one quotient bit per step. Dividend bits shift
// out of the top of dq while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module gvsf_div
    import gvsf_pkg::*;
(
    input  logic             aclk,
    input  div_ctrl_t        ctrl,
    output logic [QUO_W-1:0] dq
);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  dq_reg, dq_next;
    logic [WORD_W-1:0] divisor_reg, divisor_next;
    logic [QUO_W-1:0]  shifted;
    logic [QUO_W-1:0]  diff;
    logic              ge;

    always_comb begin
        shifted = {rem_reg, dq_reg[QUO_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        ge      = shifted >= {1'b0, divisor_reg};

        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        if (ctrl.load) begin
            rem_next     = ctrl.rem_init;
            dq_next      = ctrl.dq_init;
            divisor_next = ctrl.divisor;
        end else if (ctrl.step) begin
            rem_next = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            dq_next  = {dq_reg[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign dq = dq_reg;

endmodule

// File: sv/gouraud_vertex_setup_with_fog_top.sv
// ----------------------------------------------------------------------------
// gouraud_vertex_setup_with_fog_top
// Per-vertex setup: reciprocal depth, depth value, ARGB packing, linear fog.
// ----------------------------------------------------------------------------
// One vertex in, one result out. A vertex steps through ST_RECIP,
// ST_FOG_SETUP, ST_FOG and ST_OUT; ST_FOG is skipped when fog is off,
// suppressed, clamped or the fog range is empty, and ST_OUT waits while
// the output register holds a result not yet taken. No vertex is accepted
// until the last one's result is registered. The single radix-2 divider
// forms the Q16.16 reciprocal and the 8-bit fog quotient. A finished
// result sits in the output register while the next vertex is accepted.
// Configuration writes are always taken in the cycle they are offered.
module gouraud_vertex_setup_with_fog_top
    import gvsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // cfg: register index, data
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // slave: screen_x, screen_y, view_z, red, green, blue, alpha
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tuser,   // no_fog
    input  logic                 s_tlast,
    // master: out_x, out_y, depth_value, recip_w, packed_color, fog_factor, pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_FOG_SETUP,
        ST_FOG,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic              fog_enable_reg;
    logic [WORD_W-1:0] fog_start_reg;
    logic [WORD_W-1:0] fog_end_reg;
    logic              at_poly_start_reg;
    logic [COL_W-1:0]  poly_alpha_reg;

    logic [WORD_W-1:0] x_reg, y_reg, z_reg, recip_reg;
    logic [COL_W-1:0]  r_reg, g_reg, b_reg, fog_reg;
    logic              no_fog_reg, last_reg, fog_from_div_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tvalid_reg, m_tlast_reg;

    div_ctrl_t         div_ctrl;
    logic [QUO_W-1:0]  div_dq;

    logic              s_accept, out_free;
    logic [WORD_W-1:0] recip_sat;
    logic [WORD_W-1:0] zc, fog_dist, fog_den;
    logic [NUM_W-1:0]  fog_num;
    logic              fog_over;
    logic [COL_W-1:0]  fog_out;
    logic [DEPTH_W-1:0] depth;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    gvsf_div u_div (
        .aclk (aclk),
        .ctrl (div_ctrl),
        .dq   (div_dq)
    );

    always_comb begin
        recip_sat = (div_dq[QUO_W-1] || (z_reg == '0)) ? RECIP_SAT : div_dq[WORD_W-1:0];
        zc        = (z_reg > fog_end_reg) ? fog_end_reg : z_reg;
        fog_dist  = fog_end_reg - zc;
        fog_num   = {fog_dist, {COL_W{1'b0}}} - {{COL_W{1'b0}}, fog_dist};
        fog_den   = fog_end_reg - fog_start_reg;
        fog_over  = fog_num[NUM_W-1:COL_W] >= fog_den;
        fog_out   = fog_from_div_reg ? div_dq[COL_W-1:0] : fog_reg;
        depth     = ONE_Q16 - {1'b0, recip_reg};

        div_ctrl = '0;
        if (s_accept) begin
            div_ctrl.load     = 1'b1;
            div_ctrl.rem_init = '0;
            div_ctrl.dq_init  = RECIP_NUMER;
            div_ctrl.divisor  = s_tdata[95:64];
        end else if (state_reg == ST_FOG_SETUP) begin
            div_ctrl.load     = 1'b1;
            div_ctrl.rem_init = fog_num[NUM_W-1:COL_W];
            div_ctrl.dq_init  = {fog_num[COL_W-1:0], {(QUO_W-COL_W){1'b0}}};
            div_ctrl.divisor  = fog_den;
        end else if (state_reg == ST_RECIP || state_reg == ST_FOG) begin
            div_ctrl.step = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fog_enable_reg <= 1'b0;
            fog_start_reg  <= '0;
            fog_end_reg    <= FOG_END_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FOG_ENABLE: fog_enable_reg <= cfg_data[0];
                CFG_FOG_START:  fog_start_reg  <= cfg_data;
                CFG_FOG_END:    fog_end_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            at_poly_start_reg <= 1'b1;
            poly_alpha_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
            cnt_reg           <= '0;
            fog_from_div_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        x_reg      <= s_tdata[31:0];
                        y_reg      <= s_tdata[63:32];
                        z_reg      <= s_tdata[95:64];
                        r_reg      <= s_tdata[103:96];
                        g_reg      <= s_tdata[111:104];
                        b_reg      <= s_tdata[119:112];
                        no_fog_reg <= s_tuser;
                        last_reg   <= s_tlast;
                        if (at_poly_start_reg) begin
                            poly_alpha_reg <= s_tdata[127:120];
                        end
                        at_poly_start_reg <= s_tlast;
                        cnt_reg           <= RECIP_STEPS_M1;
                        state_reg         <= ST_RECIP;
                    end
                end
                ST_RECIP: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_FOG_SETUP;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_FOG_SETUP: begin
                    recip_reg <= recip_sat;
                    cnt_reg   <= FOG_STEPS_M1;
                    if (!fog_enable_reg || no_fog_reg) begin
                        fog_reg          <= FOG_NONE;
                        fog_from_div_reg <= 1'b0;
                        state_reg        <= ST_OUT;
                    end else if (fog_end_reg <= fog_start_reg) begin
                        fog_reg          <= (z_reg < fog_end_reg) ? FOG_FULL : FOG_NONE;
                        fog_from_div_reg <= 1'b0;
                        state_reg        <= ST_OUT;
                    end else if (fog_over) begin
                        fog_reg          <= FOG_FULL;
                        fog_from_div_reg <= 1'b0;
                        state_reg        <= ST_OUT;
                    end else begin
                        fog_from_div_reg <= 1'b1;
                        state_reg        <= ST_FOG;
                    end
                end
                ST_FOG: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {7'd0, fog_out,
                                         poly_alpha_reg, r_reg, g_reg, b_reg,
                                         recip_reg, depth, y_reg, x_reg};
                        m_tlast_reg  <= last_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: sim/gouraud_vertex_setup_with_fog_top_tb.sv
// ----------------------------------------------------------------------------
// gouraud_vertex_setup_with_fog_top_tb
// Self-checking bench for the Gouraud vertex setup block with linear fog.
// Vertices go in on the slave stream and results are checked word by word
// against a local predictor: reciprocal depth, depth value, ARGB with the
// polygon's latched alpha, and the fog factor for the current fog settings.
// The run has directed cases, a long output stall and random polygons over
// several fog settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module gouraud_vertex_setup_with_fog_top_tb;
    import gvsf_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        logic [WORD_W-1:0] sx;
        logic [WORD_W-1:0] sy;
        logic [WORD_W-1:0] z;
        logic [COL_W-1:0]  r;
        logic [COL_W-1:0]  g;
        logic [COL_W-1:0]  b;
        logic [COL_W-1:0]  a;
        logic              nofog;
        logic              last;
    } vertex_t;

    typedef struct {
        logic [WORD_W-1:0]  x;
        logic [WORD_W-1:0]  y;
        logic [DEPTH_W-1:0] depth;
        logic [WORD_W-1:0]  rhw;
        logic [WORD_W-1:0]  colour;
        logic [COL_W-1:0]   fog;
        logic               last;
    } vertex_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;   // screen_x, screen_y, view_z, r, g, b, a
    logic                 s_tuser   = 1'b0; // no_fog
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;          // x, y, depth, rhw, colour, fog, pad
    logic                 m_tlast;

    gouraud_vertex_setup_with_fog_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic              fog_en_q    = 1'b0;
    logic [WORD_W-1:0] fog_start_q = '0;
    logic [WORD_W-1:0] fog_end_q   = FOG_END_RESET;
    logic              poly_open_q = 1'b1;
    logic [COL_W-1:0]  poly_alpha_q = '0;

    vertex_result_t expected_results[$];

    int errors        = 0;
    int vertices_sent = 0;
    int results_seen  = 0;
    int polygons_sent = 0;
    int fog_settings  = 0;
    int gap_max       = 12;
    int stall_max     = 12;
    int hold_off      = 0;
    int idle_cycles   = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] recip_of(input logic [WORD_W-1:0] z);
        logic [63:0] q;
        if (z == '0)
            return RECIP_SAT;
        q = 64'h1_0000_0000 / {32'd0, z};
        if (q > 64'hFFFF_FFFF)
            return RECIP_SAT;
        return q[WORD_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] fog_of(input logic [WORD_W-1:0] z);
        logic [WORD_W-1:0] zc;
        logic [WORD_W-1:0] span;
        logic [63:0]       q;
        if (fog_end_q <= fog_start_q)
            return (z < fog_end_q) ? FOG_FULL : FOG_NONE;
        zc   = (z > fog_end_q) ? fog_end_q : z;
        span = fog_end_q - zc;
        q    = ({32'd0, span} * 64'd255) / {32'd0, fog_end_q - fog_start_q};
        return (q > 64'd255) ? FOG_FULL : q[COL_W-1:0];
    endfunction

    function automatic vertex_result_t predict_vertex(input vertex_t v);
        vertex_result_t res;
        if (poly_open_q)
            poly_alpha_q = v.a;
        res.x      = v.sx;
        res.y      = v.sy;
        res.rhw    = recip_of(v.z);
        res.depth  = ONE_Q16 - {1'b0, res.rhw};
        res.colour = {poly_alpha_q, v.r, v.g, v.b};
        res.fog    = (fog_en_q && !v.nofog) ? fog_of(v.z) : FOG_NONE;
        res.last   = v.last;
        poly_open_q = v.last;
        return res;
    endfunction

    function automatic vertex_t mk_vertex(input logic [31:0] sx, input logic [31:0] sy,
                                          input logic [31:0] z, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b,
                                          input logic [7:0] a, input logic nofog,
                                          input logic last);
        vertex_t v;
        v.sx = sx; v.sy = sy; v.z = z;
        v.r = r; v.g = g; v.b = b; v.a = a;
        v.nofog = nofog; v.last = last;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pick_depth();
        logic [WORD_W-1:0] z;
        case ($urandom_range(0, 5))
            0: z = $urandom_range(1, 64);
            1: z = fog_start_q + $urandom_range(0, 4) - 32'd2;
            2: z = fog_end_q + $urandom_range(0, 4) - 32'd2;
            3: z = (fog_end_q > fog_start_q) ?
                   fog_start_q + $urandom_range(0, fog_end_q - fog_start_q) : $urandom;
            4: z = 32'h0001_0000 + $urandom_range(0, 8) - 32'd4;
            default: z = $urandom;
        endcase
        if (z == '0)
            z = 32'd1;
        return z;
    endfunction

    function automatic void compare_field(input string name, input logic [DEPTH_W-1:0] want,
                                          input logic [DEPTH_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin : check_result
        vertex_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, tdata %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                compare_field("out_x", DEPTH_W'(want.x), DEPTH_W'(m_tdata[31:0]));
                compare_field("out_y", DEPTH_W'(want.y), DEPTH_W'(m_tdata[63:32]));
                compare_field("depth_value", want.depth, m_tdata[96:64]);
                compare_field("recip_w", DEPTH_W'(want.rhw), DEPTH_W'(m_tdata[128:97]));
                compare_field("packed_color", DEPTH_W'(want.colour),
                              DEPTH_W'(m_tdata[160:129]));
                compare_field("fog_factor", DEPTH_W'(want.fog), DEPTH_W'(m_tdata[168:161]));
                compare_field("out_last", DEPTH_W'(want.last), DEPTH_W'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // output side: random stalls, or one long hold-off on request
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge aclk);
            stall = (hold_off > 0) ? hold_off : $urandom_range(0, stall_max);
            hold_off = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid));
        end
    end

    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v.a, v.b, v.g, v.r, v.z, v.sy, v.sx};
        s_tuser  <= v.nofog;
        s_tlast  <= v.last;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_vertex(v));
        vertices_sent++;
        if (v.last)
            polygons_sent++;
    endtask

    task automatic send_polygon(input int n);
        vertex_t v;
        for (int i = 0; i < n; i++) begin
            v = mk_vertex($urandom, $urandom, pick_depth(), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, i == n - 1);
            send_vertex(v);
        end
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FOG_ENABLE: fog_en_q    = data[0];
            CFG_FOG_START:  fog_start_q = data;
            CFG_FOG_END:    fog_end_q   = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_fog(input logic en, input logic [WORD_W-1:0] fs,
                           input logic [WORD_W-1:0] fe);
        quiesce();
        cfg_write(CFG_FOG_ENABLE, {{(WORD_W-1){1'b0}}, en} | ($urandom & 32'hFFFF_FFFE));
        cfg_write(CFG_FOG_START, fs);
        cfg_write(CFG_FOG_END, fe);
        fog_settings++;
    endtask

    // fog off after reset; reciprocal saturation and unity depth
    task automatic test_recip_extremes();
        send_vertex(mk_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                              8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_vertex(mk_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002,
                              8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003,
                              8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                              8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'h0003_0000, 32'h0004_0000, 32'h0001_0000,
                              8'h80, 8'h40, 8'h20, 8'h10, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'h1234_5678, 32'h8765_4321, 32'h0001_0001,
                              8'h7F, 8'hFE, 8'h01, 8'hEE, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hFFFF_FFFF,
                              8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1));
    endtask

    // alpha comes from the first vertex of each polygon only
    task automatic test_alpha_latch();
        send_vertex(mk_vertex($urandom, $urandom, 32'h0002_0000, 8'h10, 8'h20, 8'h30,
                              8'h11, 1'b0, 1'b0));
        send_vertex(mk_vertex($urandom, $urandom, 32'h0003_0000, 8'h40, 8'h50, 8'h60,
                              8'h22, 1'b0, 1'b0));
        send_vertex(mk_vertex($urandom, $urandom, 32'h0004_0000, 8'h70, 8'h80, 8'h90,
                              8'h33, 1'b0, 1'b1));
        send_vertex(mk_vertex($urandom, $urandom, 32'h0005_0000, 8'hA0, 8'hB0, 8'hC0,
                              8'h44, 1'b0, 1'b1));
    endtask

    task automatic test_fog_linear();
        set_fog(1'b1, 32'h0001_0000, 32'h0010_0000);
        send_vertex(mk_vertex(0, 0, 32'h0000_8000, 8'h01, 8'h01, 8'h01, 8'h01, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0001_0000, 8'h02, 8'h02, 8'h02, 8'h02, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0008_8000, 8'h03, 8'h03, 8'h03, 8'h03, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0010_0000, 8'h04, 8'h04, 8'h04, 8'h04, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0020_0000, 8'h05, 8'h05, 8'h05, 8'h05, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0008_8000, 8'h06, 8'h06, 8'h06, 8'h06, 1'b1, 1'b1));
    endtask

    task automatic test_fog_empty_range();
        set_fog(1'b1, 32'h0005_0000, 32'h0005_0000);
        send_vertex(mk_vertex(0, 0, 32'h0004_FFFF, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0005_0000, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1));
        set_fog(1'b1, 32'h0009_0000, 32'h0003_0000);
        send_vertex(mk_vertex(0, 0, 32'h0002_0000, 8'h55, 8'h66, 8'h77, 8'h88, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0006_0000, 8'h55, 8'h66, 8'h77, 8'h88, 1'b0, 1'b1));
    endtask

    // a write to the spare index must leave the fog settings alone
    task automatic test_unknown_register();
        quiesce();
        cfg_write(CFG_UNMAPPED, $urandom);
        send_vertex(mk_vertex(0, 0, 32'h0002_0000, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0, 1'b0));
        send_vertex(mk_vertex(0, 0, 32'h0008_0000, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0, 1'b1));
    endtask

    task automatic test_backpressure();
        set_fog(1'b1, 32'h0000_4000, 32'h0040_0000);
        gap_max  = 0;
        hold_off = LONG_HOLD;
        send_polygon(8);
        send_polygon(8);
        gap_max = 12;
        quiesce();
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_fog(1'b0, $urandom, $urandom);
                1: set_fog(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
                2: set_fog(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
                3: begin
                    lo = $urandom;
                    set_fog(1'b1, lo, lo);
                end
                4: begin
                    lo = $urandom_range(0, 32'h0010_0000);
                    hi = lo + $urandom_range(1, 32'h0100_0000);
                    set_fog(1'b1, lo, hi);
                end
                5: begin
                    lo = $urandom_range(0, 32'hFFFF_0000);
                    hi = lo + $urandom_range(1, 300);
                    set_fog(1'b1, lo, hi);
                end
                6: begin
                    set_fog(1'b1, $urandom, $urandom);
                    cfg_write(CFG_UNMAPPED, $urandom);
                end
                default: set_fog(1'b1, 32'h0000_0000, $urandom_range(1, 32'h0004_0000));
            endcase
            sent = 0;
            while (sent < 150) begin
                if ($urandom_range(0, 3) == 0) begin
                    gap_max   = 0;
                    stall_max = 0;
                end else begin
                    gap_max   = 12;
                    stall_max = 12;
                end
                n = $urandom_range(1, 6);
                send_polygon(n);
                sent += n;
            end
        end
        gap_max   = 12;
        stall_max = 12;
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_recip_extremes();
        test_alpha_latch();
        test_fog_linear();
        test_fog_empty_range();
        test_unknown_register();
        test_backpressure();
        test_random_traffic();
        quiesce();
        $display("Run covered %0d vertices in %0d polygons, %0d results, %0d fog settings.",
                 vertices_sent, polygons_sent, results_seen, fog_settings);
        $display("Included zero and unit depth, alpha latching, empty fog ranges, long stall.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
